// File: rtl/mnbi_pkg.sv
`timescale 1ns / 1ps
package mnbi_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_M_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_N_PULSES     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BINS_PER_PRI = 2'd2;

  // Register widths and reset values
  localparam int THR_W   = 7;
  localparam int PULSE_CFG_W = 7;
  localparam int BINS_CFG_W  = 13;
  localparam logic [THR_W-1:0]       THR_RESET   = 7'd2;
  localparam logic [PULSE_CFG_W-1:0] PULSE_RESET = 7'd5;
  localparam logic [BINS_CFG_W-1:0]  BINS_RESET  = 13'd1000;

  // Hit counter entries saturate at the top of their range
  localparam int COUNT_W = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  // Result fields
  localparam int BIN_IDX_W = 12;

  // Output queue
  localparam int OUT_DEPTH = 3;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 2;

  // Per-sample control that travels with the counter request
  typedef struct packed {
    logic hit;
    logic first;
    logic emit;
    logic last_b;
  } ctl_t;

  // One result item
  typedef struct packed {
    logic                 last_bin;
    logic [BIN_IDX_W-1:0] bin_index;
    logic                 detected;
  } out_item_t;

endpackage

// File: rtl/mnbi_ctrl.sv
`timescale 1ns / 1ps
module mnbi_ctrl
  import mnbi_pkg::*;
#(
  parameter int MAX_BINS = 4096,
  parameter int MAX_PULSES = 64,
  parameter int AW = 12,
  parameter int PW = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  logic                  hit,
  output logic [AW-1:0]         req_addr,
  output ctl_t                  req_ctl,
  output logic [THR_W-1:0]      m_threshold
);

  localparam int NBW = (AW + 1 > BINS_CFG_W) ? AW + 1 : BINS_CFG_W;
  localparam int NPW = (PW + 1 > PULSE_CFG_W) ? PW + 1 : PULSE_CFG_W;

  logic [PULSE_CFG_W-1:0] n_pulses;
  logic [BINS_CFG_W-1:0]  bins_per_pri;
  logic [AW-1:0]          bin_position;
  logic [PW-1:0]          pulse_position;

  logic [NBW-1:0] nb;
  logic [NPW-1:0] np;
  logic [NBW-1:0] bin_inc;
  logic [NPW-1:0] pulse_inc;
  logic           last_b;
  logic           last_p;

  // Clamp the frame geometry to what the counter memory holds
  always_comb begin
    nb = NBW'(bins_per_pri);
    if (bins_per_pri == '0) begin
      nb = NBW'(1);
    end else if (NBW'(bins_per_pri) > NBW'(MAX_BINS)) begin
      nb = NBW'(MAX_BINS);
    end
    np = NPW'(n_pulses);
    if (n_pulses == '0) begin
      np = NPW'(1);
    end else if (NPW'(n_pulses) > NPW'(MAX_PULSES)) begin
      np = NPW'(MAX_PULSES);
    end
  end

  assign bin_inc   = NBW'(bin_position) + NBW'(1);
  assign pulse_inc = NPW'(pulse_position) + NPW'(1);
  assign last_b    = bin_inc >= nb;
  assign last_p    = pulse_inc >= np;

  assign req_addr       = bin_position;
  assign req_ctl.hit    = hit;
  assign req_ctl.first  = (pulse_position == '0);
  assign req_ctl.emit   = last_p;
  assign req_ctl.last_b = last_b;

  // Hold registers, restart the frame on any listed write, advance per sample
  always_ff @(posedge clk) begin
    if (rst) begin
      m_threshold    <= THR_RESET;
      n_pulses       <= PULSE_RESET;
      bins_per_pri   <= BINS_RESET;
      bin_position   <= '0;
      pulse_position <= '0;
    end else if (cfg_write && (cfg_index == REG_M_THRESHOLD ||
                               cfg_index == REG_N_PULSES ||
                               cfg_index == REG_BINS_PER_PRI)) begin
      unique case (cfg_index)
        REG_M_THRESHOLD: m_threshold  <= cfg_data[THR_W-1:0];
        REG_N_PULSES:    n_pulses     <= cfg_data[PULSE_CFG_W-1:0];
        default:         bins_per_pri <= cfg_data[BINS_CFG_W-1:0];
      endcase
      bin_position   <= '0;
      pulse_position <= '0;
    end else if (accept) begin
      if (last_b) begin
        bin_position   <= '0;
        pulse_position <= last_p ? '0 : pulse_inc[PW-1:0];
      end else begin
        bin_position <= bin_inc[AW-1:0];
      end
    end
  end

endmodule

// File: rtl/mnbi_count.sv
`timescale 1ns / 1ps
module mnbi_count
  import mnbi_pkg::*;
#(
  parameter int MAX_BINS = 4096,
  parameter int AW = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic [AW-1:0]    req_addr,
  input  ctl_t             req_ctl,
  input  logic [THR_W-1:0] m_threshold,
  output logic             busy,
  output logic             push,
  output out_item_t        item
);

  logic [COUNT_W-1:0] mem [MAX_BINS];
  logic [COUNT_W-1:0] rdata;

  logic               s1_valid;
  logic [AW-1:0]      s1_addr;
  ctl_t               s1_ctl;
  logic               s1_fwd;
  logic [COUNT_W-1:0] s1_fwd_data;

  logic [COUNT_W-1:0] base;
  logic [COUNT_W-1:0] count;
  logic [AW+BIN_IDX_W-1:0] addr_ext;

  // Pick the entry just written when the read raced with it
  assign base = s1_fwd ? s1_fwd_data : rdata;

  // Fresh count on the first interval, saturating add afterwards
  always_comb begin
    if (s1_ctl.first) begin
      count = COUNT_W'(s1_ctl.hit);
    end else if (s1_ctl.hit && base != COUNT_MAX) begin
      count = base + COUNT_W'(1);
    end else begin
      count = base;
    end
  end

  // Read on request, write back the updated count in the following cycle
  always_ff @(posedge clk) begin
    if (req_valid) begin
      rdata <= mem[req_addr];
    end
    if (s1_valid) begin
      mem[s1_addr] <= count;
    end
  end

  // Track the write that lands at the same edge as the new read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= req_valid;
    end
    s1_addr     <= req_addr;
    s1_ctl      <= req_ctl;
    s1_fwd      <= s1_valid && (s1_addr == req_addr);
    s1_fwd_data <= count;
  end

  assign addr_ext       = {{BIN_IDX_W{1'b0}}, s1_addr};
  assign busy           = s1_valid;
  assign push           = s1_valid && s1_ctl.emit;
  assign item.detected  = (count >= m_threshold);
  assign item.bin_index = addr_ext[BIN_IDX_W-1:0];
  assign item.last_bin  = s1_ctl.last_b;

endmodule

// File: rtl/mnbi_out_fifo.sv
`timescale 1ns / 1ps
module mnbi_out_fifo
  import mnbi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  out_item_t            push_item,
  input  logic                 pop,
  output logic                 valid,
  output out_item_t            head,
  output logic [OUT_CNT_W-1:0] level
);

  out_item_t             slots [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]  wr_ptr;
  logic [OUT_PTR_W-1:0]  rd_ptr;
  logic                  do_pop;

  assign valid  = (level != '0);
  assign head   = slots[rd_ptr];
  assign do_pop = pop && valid;

  // Store results
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr + OUT_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr + OUT_PTR_W'(1);
      end
      if (push && !do_pop) begin
        level <= level + OUT_CNT_W'(1);
      end else if (!push && do_pop) begin
        level <= level - OUT_CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/m_of_n_binary_integrator_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload                                  Request when
// s_axis    in         tdata[0] hit_bit                         tvalid && tready
// m_axis    out        tdata[0] detected, [12:1] bin_index;     tvalid && tready
//                      tlast last_bin
// cfg       in         cfg_index, cfg_data                      cfg_valid && cfg_ready
//
// One sample per cycle while the output queue has room; a result passes the
// registered counter memory read and update, then the output queue.
// Samples of one-bin frames all reuse the same entry; the write is
// forwarded into the next update. Reset clears positions and loads register
// defaults; counter entries are written fresh in the first interval of a frame.
// s_axis_tready drops once queued and in-flight results reach the three entries.
module m_of_n_binary_integrator_unit
  import mnbi_pkg::*;
#(
  parameter int MAX_BINS = 4096,
  parameter int MAX_PULSES = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [0] hit_bit
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,   // [0] detected, [12:1] bin_index
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int PW = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1;

  logic                 s_accept;
  logic                 m_accept;
  logic [AW-1:0]        req_addr;
  ctl_t                 req_ctl;
  logic [THR_W-1:0]     m_threshold;
  logic                 busy;
  logic                 push;
  out_item_t            push_item;
  out_item_t            head;
  logic [OUT_CNT_W-1:0] level;

  // Accept while the queue can absorb everything in flight
  assign cfg_ready     = 1'b1;
  assign s_axis_tready = ((OUT_CNT_W + 1)'(level) + (OUT_CNT_W + 1)'(busy))
                         < (OUT_CNT_W + 1)'(OUT_DEPTH);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_accept      = m_axis_tvalid && m_axis_tready;

  mnbi_ctrl #(
    .MAX_BINS  (MAX_BINS),
    .MAX_PULSES(MAX_PULSES),
    .AW        (AW),
    .PW        (PW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (s_accept),
    .hit        (s_axis_tdata[0]),
    .req_addr   (req_addr),
    .req_ctl    (req_ctl),
    .m_threshold(m_threshold)
  );

  mnbi_count #(
    .MAX_BINS(MAX_BINS),
    .AW      (AW)
  ) u_count (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (s_accept),
    .req_addr   (req_addr),
    .req_ctl    (req_ctl),
    .m_threshold(m_threshold),
    .busy       (busy),
    .push       (push),
    .item       (push_item)
  );

  mnbi_out_fifo u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (m_axis_tready),
    .valid    (m_axis_tvalid),
    .head     (head),
    .level    (level)
  );

  assign m_axis_tdata = {3'b000, head.bin_index, head.detected};
  assign m_axis_tlast = head.last_bin;

  // Queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && (level == OUT_CNT_W'(OUT_DEPTH)) && !m_accept))
    else $error("output queue overflow");

  // A last-interval sample yields a result on the next cycle
  a_emit_push: assert property (@(posedge clk) disable iff (rst)
    (s_accept && req_ctl.emit) |=> push)
    else $error("result of last interval missing");

  // No result without a sample accepted in the previous cycle
  a_push_src: assert property (@(posedge clk) disable iff (rst)
    push |-> $past(s_accept && req_ctl.emit))
    else $error("result without a sample");

endmodule

// File: test/m_of_n_binary_integrator_unit_tb.sv
`timescale 1ns / 1ps
module m_of_n_binary_integrator_unit_tb;
  import mnbi_pkg::*;

  localparam int BIN_SLOTS = 4096;
  localparam int PULSE_SLOTS = 64;
  localparam int RANDOM_ITEMS = 350;
  localparam int SETTLE_CYCLES = 8;
  localparam int STUCK_LIMIT = 2000;
  // Index past the register list: the block must ignore it
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  hit;
    logic                  typed;
    out_item_t             want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [15:0]           m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Detector state as the block should hold it
  logic [THR_W-1:0]       thr_reg = THR_RESET;
  logic [PULSE_CFG_W-1:0] pulses_reg = PULSE_RESET;
  logic [BINS_CFG_W-1:0]  bins_reg = BINS_RESET;
  logic [COUNT_W-1:0]     bin_hits [BIN_SLOTS];
  int unsigned            cur_bin = 0;
  int unsigned            cur_pulse = 0;

  out_item_t   decisions_due [$];
  int unsigned err_count = 0;
  int unsigned stuck_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned phase_count = 0;
  row_t        plan [0:23];

  m_of_n_binary_integrator_unit #(
    .MAX_BINS(BIN_SLOTS),
    .MAX_PULSES(PULSE_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Clamp the pulse and bin counts the way the block does
  function automatic int unsigned pulses_used();
    if (pulses_reg == 0) return 1;
    if (pulses_reg > PULSE_SLOTS) return PULSE_SLOTS;
    return pulses_reg;
  endfunction

  function automatic int unsigned bins_used();
    if (bins_reg == 0) return 1;
    if (bins_reg > BIN_SLOTS) return BIN_SLOTS;
    return bins_reg;
  endfunction

  // Fold one hit into its bin; returns 1 when the sample completes its bin
  function automatic bit integrate_sample(input logic hit, output out_item_t res);
    int unsigned cnt;
    bit end_of_pri;
    bit end_of_frame;
    if (cur_pulse == 0) begin
      cnt = hit;
    end else begin
      cnt = bin_hits[cur_bin] + hit;
    end
    if (cnt > COUNT_MAX) cnt = COUNT_MAX;
    bin_hits[cur_bin] = COUNT_W'(cnt);
    end_of_pri = (cur_bin + 1) >= bins_used();
    end_of_frame = (cur_pulse + 1) >= pulses_used();
    res.detected = (cnt >= thr_reg);
    res.bin_index = BIN_IDX_W'(cur_bin);
    res.last_bin = end_of_pri;
    if (end_of_pri) begin
      cur_bin = 0;
      cur_pulse = end_of_frame ? 0 : cur_pulse + 1;
    end else begin
      cur_bin = cur_bin + 1;
    end
    return end_of_frame;
  endfunction

  // Drop the sample stream, let every decision drain, then let the pipe settle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (decisions_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_M_THRESHOLD:  thr_reg = val[THR_W-1:0];
      REG_N_PULSES:     pulses_reg = val[PULSE_CFG_W-1:0];
      REG_BINS_PER_PRI: bins_reg = val[BINS_CFG_W-1:0];
      default: ;
    endcase
    // Any listed register restarts the frame
    if (idx != REG_UNMAPPED) begin
      cur_bin = 0;
      cur_pulse = 0;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Offer one sample after a random gap; hold it until the request is taken
  task automatic push_sample(input logic hit, input logic typed, input out_item_t want);
    out_item_t res;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, hit};
    do @(posedge clk); while (!s_axis_tready);
    if (integrate_sample(hit, res)) decisions_due.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
      default: begin send_idle_pct = 30; recv_stall_pct = 30; end
    endcase
  endtask

  // Write the chosen registers, then stream whole frames plus an optional ragged tail
  task automatic run_phase(input logic [3:0] wr, input logic [CFG_DATA_W-1:0] thr_v,
                           input logic [CFG_DATA_W-1:0] pul_v,
                           input logic [CFG_DATA_W-1:0] bins_v, input int unsigned frames,
                           input bit ragged, input int unsigned hit_pct,
                           output int unsigned n_items);
    int unsigned frame_len;
    if (wr[REG_UNMAPPED]) write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom()));
    if (wr[REG_M_THRESHOLD]) write_reg(REG_M_THRESHOLD, thr_v);
    if (wr[REG_N_PULSES]) write_reg(REG_N_PULSES, pul_v);
    if (wr[REG_BINS_PER_PRI]) write_reg(REG_BINS_PER_PRI, bins_v);
    set_idling(phase_count);
    phase_count++;
    frame_len = pulses_used() * bins_used();
    if (frame_len > 256 && frames > 1) frames = 1;
    n_items = frames * frame_len;
    if (ragged) n_items += $urandom_range(frame_len - 1, 0);
    repeat (n_items) push_sample($urandom_range(99, 0) < hit_pct, 1'b0, '0);
  endtask

  // Receiver: stall at random
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // Compare each decision with the oldest one due
  always @(posedge clk) begin : check_decisions
    out_item_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (decisions_due.size() == 0) begin
        $error("unexpected decision: bin_index %0d", m_axis_tdata[12:1]);
        err_count++;
      end else begin
        want = decisions_due.pop_front();
        if (m_axis_tdata[0] !== want.detected) begin
          $error("detected: expected %0d, got %0d", want.detected, m_axis_tdata[0]);
          err_count++;
        end
        if (m_axis_tdata[12:1] !== want.bin_index) begin
          $error("bin_index: expected %0d, got %0d", want.bin_index, m_axis_tdata[12:1]);
          err_count++;
        end
        if (m_axis_tlast !== want.last_bin) begin
          $error("last_bin: expected %0d, got %0d", want.last_bin, m_axis_tlast);
          err_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no request moves for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int unsigned rand_items;
    int unsigned got;
    int unsigned r;
    int unsigned n_val;
    int unsigned np;
    int unsigned b_val;
    int unsigned m_val;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rand_items = 0;

    // Directed: reset settings, unmapped index, clamped sizes, threshold zero,
    // threshold at and above the pulse count
    plan = '{
      '{ROW_SAMPLE, '0, '0, 1'b1, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 1'b0, 1'b0, '0},
      '{ROW_WRITE, REG_UNMAPPED, 13'h1FFF, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 1'b1, 1'b0, '0},
      '{ROW_WRITE, REG_M_THRESHOLD, 13'h1F80, 1'b0, 1'b0, '0},
      '{ROW_WRITE, REG_N_PULSES, 13'h1F80, 1'b0, 1'b0, '0},
      '{ROW_WRITE, REG_BINS_PER_PRI, 13'h0000, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 1'b0, 1'b1, '{1'b1, 12'd0, 1'b1}},
      '{ROW_SAMPLE, '0, '0, 1'b1, 1'b1, '{1'b1, 12'd0, 1'b1}},
      '{ROW_WRITE, REG_M_THRESHOLD, 13'd1, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 1'b0, 1'b1, '{1'b1, 12'd0, 1'b0}},
      '{ROW_SAMPLE, '0, '0, 1'b1, 1'b1, '{1'b1, 12'd0, 1'b1}},
      '{ROW_WRITE, REG_N_PULSES, 13'd2, 1'b0, 1'b0, '0},
      '{ROW_WRITE, REG_BINS_PER_PRI, 13'd2, 1'b0, 1'b0, '0},
      '{ROW_WRITE, REG_M_THRESHOLD, 13'd2, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 1'b1, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 1'b1, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 1'b1, 1'b1, '{1'b0, 12'd0, 1'b1}},
      '{ROW_SAMPLE, '0, '0, 1'b0, 1'b1, '{1'b1, 12'd1, 1'b0}},
      '{ROW_WRITE, REG_M_THRESHOLD, 13'd3, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 1'b1, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 1'b1, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 1'b1, 1'b1, '{1'b0, 12'd0, 1'b0}},
      '{ROW_SAMPLE, '0, '0, 1'b1, 1'b1, '{1'b1, 12'd1, 1'b0}}
    };

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    set_idling(3);
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        push_sample(plan[i].hit, plan[i].typed, plan[i].want);
      end
    end

    // Register extremes: threshold out of reach, clamped pulse count,
    // a long interval, threshold zero
    run_phase(4'b0111, 13'h1FFF, 13'd64, 13'd1, 1, 1'b0, 95, got);
    run_phase(4'b0111, 13'd64, 13'h007F, 13'd2, 1, 1'b0, 99, got);
    run_phase(4'b0111, 13'd1, 13'd1, 13'd300, 1, 1'b0, 50, got);
    run_phase(4'b1111, 13'd0, 13'd65, 13'd3, 1, 1'b1, 10, got);

    // Random settings, mostly small frames
    while (rand_items < RANDOM_ITEMS) begin
      r = $urandom_range(9, 0);
      n_val = (r == 0) ? 0 : (r == 1) ? $urandom_range(127, 65) : $urandom_range(6, 1);
      np = (n_val == 0) ? 1 : (n_val > PULSE_SLOTS) ? PULSE_SLOTS : n_val;
      r = $urandom_range(9, 0);
      b_val = (r == 0) ? 0 : (r == 1) ? $urandom_range(24, 13) : $urandom_range(12, 1);
      if (np > 8) b_val = $urandom_range(3, 0);
      r = $urandom_range(9, 0);
      m_val = (r == 0) ? 0 : (r == 1) ? $urandom_range(127, 0) : $urandom_range(np + 1, 1);
      run_phase(4'($urandom_range(15, 0)), {6'($urandom()), 7'(m_val)},
                {6'($urandom()), 7'(n_val)}, 13'(b_val), $urandom_range(3, 1),
                $urandom_range(2, 0) == 0, $urandom_range(100, 0), got);
      rand_items += got;
    end

    wait_drained();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
